// ----- rtl/ppgt_pkg.sv -----
// shared types and constants of the prefix pattern group table
`default_nettype none
package ppgt_pkg;

   localparam int NAME_BYTES = 15;
   localparam int NAME_CHARS = 15;
   localparam int NAME_BITS  = 8 * NAME_BYTES;
   localparam logic [31:0] ANY_USER = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_DELETE = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ADDR_IDX  = 2'd0,
      ADDR_NEXT = 2'd1,
      ADDR_PREV = 2'd2
   } addr_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LK_RD,
      ST_LK_CHK,
      ST_EQ_RD,
      ST_EQ_CHK,
      ST_RM_RD,
      ST_RM_WR,
      ST_INS_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [31:0] group_value;
      logic [31:0]        user_key;
      logic [55:0]        parent_high;
      logic [63:0]        parent_low;
      logic [55:0]        name_high;
      logic [63:0]        name_low;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic         req_load;
      logic         idx_clr;
      logic         idx_load_count;
      logic         idx_inc;
      logic         idx_dec;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         wr_en;
      logic         wr_new;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         set_hit;
      logic         set_not_found;
      logic         set_full;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       idx_end;
      logic       idx_last;
      logic       idx_zero;
      logic       full;
      logic       lk_match;
      logic       eq_match;
      logic       rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/ppgt_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module ppgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/ppgt_ctrl.sv -----
// sequencer for lookup, add and delete over the pattern table
`default_nettype none
module ppgt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire ppgt_pkg::sts_type sts,
   output ppgt_pkg::cmd_type     cmd
);

   ppgt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppgt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.addr_sel = ppgt_pkg::ADDR_IDX;
      req_tready = 1'b0;
      case (state_ff)
         ppgt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               cmd.idx_clr  = 1'b1;
               state_in     = ppgt_pkg::ST_DISPATCH;
            end
         end
         ppgt_pkg::ST_DISPATCH: begin
            // the kind register holds the word just taken
            case (ppgt_pkg::req_kind_type'(sts.kind))
               ppgt_pkg::REQ_LOOKUP: state_in = ppgt_pkg::ST_LK_RD;
               ppgt_pkg::REQ_ADD:    state_in = ppgt_pkg::ST_EQ_RD;
               ppgt_pkg::REQ_DELETE: state_in = ppgt_pkg::ST_EQ_RD;
               default:              state_in = ppgt_pkg::ST_FIN;
            endcase
         end
         ppgt_pkg::ST_LK_RD: begin
            if (sts.idx_end) begin
               state_in = ppgt_pkg::ST_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ppgt_pkg::ST_LK_CHK;
            end
         end
         ppgt_pkg::ST_LK_CHK: begin
            if (sts.lk_match) begin
               cmd.set_hit = 1'b1;
               state_in    = ppgt_pkg::ST_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ppgt_pkg::ST_LK_RD;
            end
         end
         ppgt_pkg::ST_EQ_RD: begin
            if (sts.idx_end) begin
               if (sts.kind == ppgt_pkg::REQ_DELETE) begin
                  cmd.set_not_found = 1'b1;
                  state_in          = ppgt_pkg::ST_FIN;
               end else begin
                  state_in = ppgt_pkg::ST_INS_CHK;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ppgt_pkg::ST_EQ_CHK;
            end
         end
         ppgt_pkg::ST_EQ_CHK: begin
            if (sts.eq_match) begin
               state_in = ppgt_pkg::ST_RM_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ppgt_pkg::ST_EQ_RD;
            end
         end
         ppgt_pkg::ST_RM_RD: begin
            if (sts.idx_last) begin
               cmd.cnt_dec = 1'b1;
               if (sts.kind == ppgt_pkg::REQ_ADD) begin
                  state_in = ppgt_pkg::ST_INS_CHK;
               end else begin
                  state_in = ppgt_pkg::ST_FIN;
               end
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ppgt_pkg::ADDR_NEXT;
               state_in     = ppgt_pkg::ST_RM_WR;
            end
         end
         ppgt_pkg::ST_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = ppgt_pkg::ST_RM_RD;
         end
         ppgt_pkg::ST_INS_CHK: begin
            if (sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = ppgt_pkg::ST_FIN;
            end else begin
               cmd.idx_load_count = 1'b1;
               state_in           = ppgt_pkg::ST_SH_RD;
            end
         end
         ppgt_pkg::ST_SH_RD: begin
            if (sts.idx_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = ppgt_pkg::ST_FIN;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ppgt_pkg::ADDR_PREV;
               state_in     = ppgt_pkg::ST_SH_WR;
            end
         end
         ppgt_pkg::ST_SH_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = ppgt_pkg::ST_SH_RD;
         end
         ppgt_pkg::ST_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ppgt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppgt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ppgt_dp.sv -----
// request register, pattern memory, index and count, match logic and result register
`default_nettype none
module ppgt_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppgt_pkg::cmd_type             cmd,
   output ppgt_pkg::sts_type                  sts,
   input  wire logic [ppgt_pkg::ENTRY_BITS-1:0] req_tdata,
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic signed [31:0]                 rsp_group,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_hit
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   function automatic logic [ppgt_pkg::NAME_BITS-1:0] canon(
      input logic [ppgt_pkg::NAME_BITS-1:0] v
   );
      logic [ppgt_pkg::NAME_BITS-1:0] r;
      logic ended;
      r     = '0;
      ended = 1'b0;
      for (int i = 0; i < ppgt_pkg::NAME_BYTES; i++) begin
         if (i >= ppgt_pkg::NAME_CHARS || v[8*i +: 8] == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            r[8*i +: 8] = v[8*i +: 8];
         end
      end
      return r;
   endfunction

   // stored prefixes are canonical: their nonzero bytes form the prefix
   function automatic logic prefix_hit(
      input logic [ppgt_pkg::NAME_BITS-1:0] pat,
      input logic [ppgt_pkg::NAME_BITS-1:0] name
   );
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < ppgt_pkg::NAME_BYTES; i++) begin
         if (pat[8*i +: 8] != 8'd0 && pat[8*i +: 8] != name[8*i +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   ppgt_pkg::entry_type req_ff, req_in, raw, rd_entry, wr_entry;
   logic [1:0]          kind_ff;
   logic [CW-1:0]       idx_ff, idx_in, cnt_ff, cnt_in, addr_full;
   logic [CW:0]         idx_next;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_ff, res_hit_ff;
   logic signed [31:0]  group_ff, res_group_ff;
   logic [1:0]          status_ff, res_status_ff;
   logic [ppgt_pkg::ENTRY_BITS-1:0] rd_bits;
   logic [ppgt_pkg::NAME_BITS-1:0]  req_name, req_parent, st_name, st_parent;

   assign raw = ppgt_pkg::entry_type'(req_tdata);

   always_comb begin
      req_in = raw;
      {req_in.name_high, req_in.name_low}     = canon({raw.name_high, raw.name_low});
      {req_in.parent_high, req_in.parent_low} = canon({raw.parent_high, raw.parent_low});
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff  <= req_in;
         kind_ff <= req_tuser;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_load_count) begin
         idx_in = cnt_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      case (cmd.addr_sel)
         ppgt_pkg::ADDR_NEXT: addr_full = idx_ff + 1'b1;
         ppgt_pkg::ADDR_PREV: addr_full = idx_ff - 1'b1;
         default:             addr_full = idx_ff;
      endcase
   end

   assign wr_entry = cmd.wr_new ? req_ff : rd_entry;

   ppgt_ram #(
      .WIDTH(ppgt_pkg::ENTRY_BITS),
      .DEPTH(TABLE_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(idx_ff[AW-1:0]),
      .wr_data(wr_entry),
      .rd_en  (cmd.rd_en),
      .rd_addr(addr_full[AW-1:0]),
      .rd_data(rd_bits)
   );

   assign rd_entry   = ppgt_pkg::entry_type'(rd_bits);
   assign req_name   = {req_ff.name_high, req_ff.name_low};
   assign req_parent = {req_ff.parent_high, req_ff.parent_low};
   assign st_name    = {rd_entry.name_high, rd_entry.name_low};
   assign st_parent  = {rd_entry.parent_high, rd_entry.parent_low};
   assign idx_next   = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      sts.kind     = kind_ff;
      sts.idx_end  = idx_ff >= cnt_ff;
      sts.idx_last = idx_next >= {1'b0, cnt_ff};
      sts.idx_zero = idx_ff == '0;
      sts.full     = cnt_ff >= CW'(TABLE_ENTRIES);
      sts.lk_match = prefix_hit(st_name, req_name) && prefix_hit(st_parent, req_parent)
                     && (rd_entry.user_key == ppgt_pkg::ANY_USER
                         || rd_entry.user_key == req_ff.user_key);
      sts.eq_match = st_name == req_name && st_parent == req_parent
                     && rd_entry.user_key == req_ff.user_key;
      sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         hit_ff    <= 1'b0;
         group_ff  <= '0;
         status_ff <= ppgt_pkg::STATUS_OK;
      end else begin
         if (cmd.set_hit) begin
            hit_ff   <= 1'b1;
            group_ff <= rd_entry.group_value;
         end
         if (cmd.set_not_found) begin
            status_ff <= ppgt_pkg::STATUS_NOT_FOUND;
         end
         if (cmd.set_full) begin
            status_ff <= ppgt_pkg::STATUS_FULL;
         end
      end
      if (cmd.rsp_load) begin
         res_hit_ff    <= hit_ff;
         res_group_ff  <= group_ff;
         res_status_ff <= status_ff;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_group  = res_group_ff;
   assign rsp_status = res_status_ff;
   assign rsp_hit    = res_hit_ff;

endmodule
`default_nettype wire

// ----- rtl/prefix_pattern_group_table.sv -----
// top level of the prefix pattern group table
//
// req channel: one word per request, tuser carries the kind (lookup, add,
// delete), tdata the name and parent prefixes, the user id and the group.
// rsp channel: one word per request, tdata carries group and status, tuser
// the lookup hit flag.
// a request is taken only while the sequencer is idle; in the cycle after it is
// taken the dispatch state decodes the kind. the table lives in a single ram with
// one read and one write port, so every entry visited takes a read state and
// then a compare or copy state.
// lookup: scan from the first entry, stopping at the first match or at the end.
// add: equal search, removal copy and insert shift.
// delete: equal search plus removal copy.
// results wait in an output register; the next request is taken while a
// result is held, and a finished request waits there until rsp_tready frees
// the register.
// reset empties the table at once (the entry count clears); no sweep is run.
`default_nettype none
module prefix_pattern_group_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // name_low, name_high, parent_low, parent_high, user_key, group_value
   input  wire logic [ppgt_pkg::ENTRY_BITS-1:0] req_tdata,
   // req_type
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // group_out, status, zero fill
   output logic [39:0]                        rsp_tdata,
   // hit
   output logic                               rsp_tuser
);

   ppgt_pkg::cmd_type cmd;
   ppgt_pkg::sts_type sts;
   logic signed [31:0] group_out;
   logic [1:0]         status;

   ppgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppgt_dp #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_group (group_out),
      .rsp_status(status),
      .rsp_hit   (rsp_tuser)
   );

   assign rsp_tdata = {6'd0, status, group_out};

endmodule
`default_nettype wire

// ----- tb/prefix_pattern_group_table_test.sv -----
// self-checking bench for the prefix pattern group table: random and directed requests
`default_nettype none
module prefix_pattern_group_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [63:0] name_lo;
      logic [55:0] name_hi;
      logic [63:0] par_lo;
      logic [55:0] par_hi;
      logic [31:0] user;
      logic [31:0] group;
   } pattern_type;

   typedef struct {
      logic [31:0] group;
      logic        hit;
      logic [1:0]  status;
   } answer_type;

   class group_table_scoreboard;
      pattern_type rows[DEPTH];
      int          count;
      answer_type  pending[$];
      int          errors;

      function void clear();
         count = 0;
         pending.delete();
         errors = 0;
      endfunction

      // zero every byte after the first zero byte
      function automatic logic [119:0] trim(logic [119:0] raw);
         logic [119:0] res;
         bit ended;
         res = '0;
         ended = 0;
         for (int i = 0; i < ppgt_pkg::NAME_CHARS; i++) begin
            if (raw[8*i +: 8] == 8'd0) ended = 1;
            if (!ended) res[8*i +: 8] = raw[8*i +: 8];
         end
         return res;
      endfunction

      function automatic bit prefix_ok(logic [119:0] pre, logic [119:0] nm);
         for (int i = 0; i < ppgt_pkg::NAME_CHARS; i++) begin
            if (pre[8*i +: 8] == 8'd0) return 1;
            if (pre[8*i +: 8] != nm[8*i +: 8]) return 0;
         end
         return 1;
      endfunction

      function automatic bit same(pattern_type a, pattern_type b);
         return a.name_lo == b.name_lo && a.name_hi == b.name_hi &&
                a.par_lo == b.par_lo && a.par_hi == b.par_hi && a.user == b.user;
      endfunction

      function automatic bit drop_equal(pattern_type p);
         for (int i = 0; i < count; i++)
            if (same(rows[i], p)) begin
               for (int j = i; j + 1 < count; j++) rows[j] = rows[j+1];
               count--;
               return 1;
            end
         return 0;
      endfunction

      function void note_request(logic [1:0] kind, ppgt_pkg::entry_type e);
         pattern_type p;
         answer_type a;
         logic [119:0] n, q;
         n = trim({e.name_high, e.name_low});
         q = trim({e.parent_high, e.parent_low});
         p.name_lo = n[63:0];  p.name_hi = n[119:64];
         p.par_lo = q[63:0];   p.par_hi = q[119:64];
         p.user = e.user_key;  p.group = e.group_value;
         a = '{32'd0, 1'b0, ppgt_pkg::STATUS_OK};
         case (kind)
            ppgt_pkg::REQ_LOOKUP: begin
               for (int i = 0; i < count; i++)
                  if (prefix_ok({rows[i].name_hi, rows[i].name_lo}, n) &&
                      prefix_ok({rows[i].par_hi, rows[i].par_lo}, q) &&
                      (rows[i].user == ppgt_pkg::ANY_USER || rows[i].user == p.user)) begin
                     a.group = rows[i].group;
                     a.hit = 1;
                     break;
                  end
            end
            ppgt_pkg::REQ_ADD: begin
               void'(drop_equal(p));
               if (count >= DEPTH) a.status = ppgt_pkg::STATUS_FULL;
               else begin
                  for (int i = count; i > 0; i--) rows[i] = rows[i-1];
                  rows[0] = p;
                  count++;
               end
            end
            ppgt_pkg::REQ_DELETE:
               if (!drop_equal(p)) a.status = ppgt_pkg::STATUS_NOT_FOUND;
            default: ;
         endcase
         pending.push_back(a);
      endfunction

      function void check_result(logic [39:0] data, logic hit);
         answer_type a;
         if (pending.size() == 0) begin
            report("result with nothing pending");
            return;
         end
         a = pending.pop_front();
         if (data[31:0] !== a.group) report("group_out differs");
         if (data[33:32] !== a.status) report("status differs");
         if (data[39:34] !== '0) report("fill bits set");
         if (hit !== a.hit) report("hit differs");
      endfunction

      function void report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [ppgt_pkg::ENTRY_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic rsp_tuser;

   group_table_scoreboard board = new();
   int cycles = 0;
   int hold_off = 0;
   bit stall_random = 1;

   prefix_pattern_group_table dut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver side: random stalls and one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (!stall_random) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 60) == 0 ? 0 : 0);
   end

   // small alphabet so prefixes collide often
   function automatic logic [119:0] pick_name();
      logic [119:0] v;
      int len, mode;
      v = '0;
      mode = $urandom_range(0, 9);
      if (mode == 0) return 120'({$urandom, $urandom, $urandom, $urandom});
      len = (mode == 1) ? 15 : $urandom_range(0, 4);
      for (int i = 0; i < len; i++)
         v[8*i +: 8] = (mode == 1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(97, 99));
      if ($urandom_range(0, 7) == 0) v[8*(len + 1) % 120 +: 8] = 8'($urandom);
      return v;
   endfunction

   function automatic logic [31:0] pick_user();
      case ($urandom_range(0, 5))
         0: return ppgt_pkg::ANY_USER;
         1: return $urandom;
         default: return 32'($urandom_range(0, 2));
      endcase
   endfunction

   task automatic gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send(logic [1:0] kind, logic [119:0] nm, logic [119:0] pr,
                       logic [31:0] user, logic [31:0] grp);
      ppgt_pkg::entry_type e;
      e.name_low = nm[63:0];   e.name_high = nm[119:64];
      e.parent_low = pr[63:0]; e.parent_high = pr[119:64];
      e.user_key = user;       e.group_value = grp;
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= e;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, e);
   endtask

   task automatic send_random(int weight_add);
      int r;
      logic [1:0] kind;
      r = $urandom_range(0, 99);
      kind = (r < weight_add) ? ppgt_pkg::REQ_ADD :
             (r < weight_add + 20) ? ppgt_pkg::REQ_DELETE :
             (r < 97) ? ppgt_pkg::REQ_LOOKUP : 2'd3;
      send(kind, pick_name(), pick_name(), pick_user(), $urandom);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [119:0] full_name;
      board.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      full_name = {15{8'hFF}};
      // directed part
      send(ppgt_pkg::REQ_LOOKUP, '0, '0, '0, '0);
      send(ppgt_pkg::REQ_DELETE, '0, '0, '0, '0);
      send(ppgt_pkg::REQ_ADD, '0, '0, ppgt_pkg::ANY_USER, 32'h8000_0000);
      send(ppgt_pkg::REQ_LOOKUP, full_name, full_name, 32'h1234, '0);
      send(ppgt_pkg::REQ_ADD, full_name, full_name, '0, 32'h7FFF_FFFF);
      send(ppgt_pkg::REQ_ADD, {8'h00, 8'h61, 8'h00, 8'h62}, '0, 32'd1, 32'd5);
      send(ppgt_pkg::REQ_LOOKUP, full_name, full_name, '0, '0);
      send(ppgt_pkg::REQ_LOOKUP, 120'h6162, '0, 32'd1, '0);
      send(ppgt_pkg::REQ_ADD, 120'h62, '0, 32'd1, 32'd9);
      send(ppgt_pkg::REQ_LOOKUP, 120'h62, '0, 32'd1, '0);
      send(ppgt_pkg::REQ_DELETE, 120'h62, '0, 32'd1, '0);
      send(ppgt_pkg::REQ_DELETE, 120'h62, '0, 32'd1, '0);
      send(2'd3, full_name, full_name, ppgt_pkg::ANY_USER, 32'hFFFF_FFFF);
      for (int i = 0; i < 17; i++) send(ppgt_pkg::REQ_ADD, 120'(i + 1), '0, 32'd7, i);
      send(ppgt_pkg::REQ_ADD, 120'd3, '0, 32'd7, 32'd99);
      send(ppgt_pkg::REQ_LOOKUP, 120'd3, '0, 32'd7, '0);
      drain();
      // long receiver hold-off while the sender keeps offering
      hold_off = 200;
      for (int i = 0; i < 20; i++) send_random(30);
      drain();
      // random part, shifting the add/delete balance so the table fills and empties
      for (int i = 0; i < 1800; i++) begin
         send_random(((i / 150) % 2 == 0) ? 50 : 10);
         gap();
      end
      stall_random = 0;
      drain();
      repeat (150) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
